>>> src/amx_pkg.sv
// ----------------------------------------------------------------------------
// amx_pkg
// Shared types and constants for the array machine execute unit.
// ----------------------------------------------------------------------------
package amx_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned KindW = 4;
  localparam int unsigned ImmW = 25;
  localparam logic [WordW-1:0] OutMax = 32'd255;

  typedef enum logic [KindW-1:0] {
    K_DONE  = 4'd0,
    K_READ  = 4'd1,
    K_WRITE = 4'd2,
    K_ALLOC = 4'd3,
    K_FREE  = 4'd4,
    K_OUT   = 4'd5,
    K_IN    = 4'd6,
    K_LOAD  = 4'd7,
    K_HALT  = 4'd8,
    K_FAULT = 4'd9
  } kind_t;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_READ  = 4'd1,
    OP_WRITE = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_ALLOC = 4'd8,
    OP_FREE  = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LOAD  = 4'd12,
    OP_ORTHO = 4'd13
  } opc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // latch input word
    logic exec;        // read operands, decode
    logic div_start;
    logic div_step;
    logic commit;      // write back, form result
    logic out_clear;   // result taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;
    logic div_done;
  } sts_t;

endpackage

>>> src/amx_ctrl.sv
// ----------------------------------------------------------------------------
// amx_ctrl
// Sequencer: accept, execute, optional divide loop, commit, present result.
// ----------------------------------------------------------------------------
module amx_ctrl
  import amx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.is_div ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.div_start = sts.is_div;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_WB: begin
        cmd.commit = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        cmd.out_clear = out_ready;
        cmd.load_item = out_ready & in_valid;
      end
      default: ;
    endcase
  end

endmodule

>>> src/amx_dp.sv
// ----------------------------------------------------------------------------
// amx_dp
// Register file, program counter, pending target, ALU with a radix-2
// restoring divider, and the result register.
// ----------------------------------------------------------------------------
module amx_dp
  import amx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_op,
  input  logic [WordW-1:0] in_instr,
  input  logic [WordW-1:0] in_resp,
  output logic [KindW-1:0] out_kind,
  output logic [WordW-1:0] out_aid,
  output logic [WordW-1:0] out_off,
  output logic [WordW-1:0] out_data,
  output logic [WordW-1:0] out_pc
);

  logic [WordW-1:0]   regs_r [NumRegs];
  logic [WordW-1:0]   pc_r;
  logic [RegIdxW-1:0] pend_r;
  logic               pendv_r;

  logic               op_r;
  logic [WordW-1:0]   iw_r, resp_r;

  // operand stage
  logic [WordW-1:0]   ra_r, rb_r, rc_r;

  // divider
  logic [WordW-1:0]   quo_r, rem_r;
  logic [5:0]         dcnt_r;

  // result
  logic [KindW-1:0]   kind_r;
  logic [WordW-1:0]   aid_r, off_r, data_r;

  logic [3:0]         opc;
  logic [RegIdxW-1:0] ia, ib, ic, io;
  assign opc = iw_r[31:28];
  assign ia = iw_r[8:6];
  assign ib = iw_r[5:3];
  assign ic = iw_r[2:0];
  assign io = iw_r[27:25];

  assign sts.is_div = (!op_r) && (opc == OP_DIV) && (regs_r[ic] != '0);
  assign sts.div_done = (dcnt_r == 6'd0);

  logic [WordW:0] rem_sh;
  logic [WordW:0] rem_sub;
  assign rem_sh = {rem_r, quo_r[WordW-1]};
  assign rem_sub = rem_sh - {1'b0, rc_r};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= in_op;
      iw_r <= in_instr;
      resp_r <= in_resp;
    end
    if (cmd.exec) begin
      ra_r <= regs_r[ia];
      rb_r <= regs_r[ib];
      rc_r <= regs_r[ic];
    end
    if (cmd.div_start) begin
      quo_r <= regs_r[ib];
      rem_r <= '0;
      dcnt_r <= 6'(WordW);
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!rem_sub[WordW]) begin
        rem_r <= rem_sub[WordW-1:0];
        quo_r <= {quo_r[WordW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WordW-1:0];
        quo_r <= {quo_r[WordW-2:0], 1'b0};
      end
    end
  end

  logic [WordW-1:0] prod;
  assign prod = rb_r * rc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) regs_r[i] <= '0;
      pc_r <= '0;
      pend_r <= '0;
      pendv_r <= 1'b0;
      kind_r <= K_DONE;
    end else if (cmd.commit) begin
      aid_r <= '0;
      off_r <= '0;
      data_r <= '0;
      kind_r <= K_DONE;
      if (op_r) begin
        if (pendv_r) regs_r[pend_r] <= resp_r;
        pendv_r <= 1'b0;
      end else begin
        pendv_r <= 1'b0;
        pc_r <= pc_r + 32'd1;
        case (opc)
          OP_CMOV: if (rc_r != '0) regs_r[ia] <= rb_r;
          OP_READ: begin
            kind_r <= K_READ; aid_r <= rb_r; off_r <= rc_r;
            pend_r <= ia; pendv_r <= 1'b1;
          end
          OP_WRITE: begin
            kind_r <= K_WRITE; aid_r <= ra_r; off_r <= rb_r; data_r <= rc_r;
          end
          OP_ADD:  regs_r[ia] <= rb_r + rc_r;
          OP_MUL:  regs_r[ia] <= prod;
          OP_DIV: begin
            if (rc_r == '0) kind_r <= K_FAULT;
            else regs_r[ia] <= quo_r;
          end
          OP_NAND: regs_r[ia] <= ~(rb_r & rc_r);
          OP_HALT: kind_r <= K_HALT;
          OP_ALLOC: begin
            kind_r <= K_ALLOC; off_r <= rc_r; pend_r <= ib; pendv_r <= 1'b1;
          end
          OP_FREE: begin
            kind_r <= K_FREE; aid_r <= rc_r;
          end
          OP_OUT: begin
            if (rc_r > OutMax) kind_r <= K_FAULT;
            else begin
              kind_r <= K_OUT; data_r <= rc_r;
            end
          end
          OP_IN: begin
            kind_r <= K_IN; pend_r <= ic; pendv_r <= 1'b1;
          end
          OP_LOAD: begin
            kind_r <= K_LOAD; aid_r <= rb_r; pc_r <= rc_r;
          end
          OP_ORTHO: regs_r[io] <= {{(WordW-ImmW){1'b0}}, iw_r[ImmW-1:0]};
          default: kind_r <= K_FAULT;
        endcase
      end
    end
  end

  assign out_kind = kind_r;
  assign out_aid = aid_r;
  assign out_off = off_r;
  assign out_data = data_r;
  assign out_pc = pc_r;

endmodule

>>> src/array_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// array_machine_execute_unit_core
// Execute unit for the fourteen-opcode array machine.
// Per word: accept, execute, commit, present; a divide with nonzero divisor adds a radix-2 loop.
// One word at a time: no new word is accepted before the last result is taken.
// The result register holds the word until taken; next input accepted then.
// Reset (rst_n low, synchronous) clears registers, pc and pending target.
// ----------------------------------------------------------------------------
module array_machine_execute_unit_core
  import amx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // instruction_word[31:0], response_word[63:32]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [127:0] out_tdata, // array_id, word_offset, data_word, next_pc
  output logic [3:0]  out_tuser   // request_kind
);

  cmd_t cmd;
  sts_t sts;
  logic [WordW-1:0] aid, off, dat, pc;

  amx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  amx_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_op   (in_tuser),
    .in_instr(in_tdata[31:0]),
    .in_resp (in_tdata[63:32]),
    .out_kind(out_tuser),
    .out_aid (aid),
    .out_off (off),
    .out_data(dat),
    .out_pc  (pc)
  );

  assign out_tdata = {pc, dat, off, aid};

endmodule

>>> bench/array_machine_execute_unit_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_machine_execute_unit_core_test
// Drives instruction and response words into the execute unit, predicts
// each result from a private copy of registers, pc and pending target, and
// compares every result field. Directed table first, then random programs.
// ----------------------------------------------------------------------------
module array_machine_execute_unit_core_test;
  import amx_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandWords = 980;

  typedef struct packed {
    kind_t      kind;
    logic [31:0] aid;
    logic [31:0] off;
    logic [31:0] data;
    logic [31:0] pc;
  } result_t;

  typedef struct {
    logic        resp;
    logic [31:0] word;
    logic        typed;
    result_t     res;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;  // instruction_word, response_word
  logic in_tuser = 1'b0;       // op
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;     // array_id, word_offset, data_word, next_pc
  logic [3:0] out_tuser;       // request_kind

  logic [31:0] regs_m [8];
  logic [31:0] pc_m;
  logic [2:0] pend_reg_m;
  logic pend_m;
  result_t expected_q [$];
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  logic quiet = 1'b0;
  logic hold_rx = 1'b0;
  stim_t table_d [$];

  array_machine_execute_unit_core dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic result_t execute_word(logic resp, logic [31:0] word, logic [31:0] rw);
    result_t r;
    logic [3:0] opc;
    logic [2:0] a, b, c;
    r = '{kind: K_DONE, default: '0};
    if (resp) begin
      if (pend_m) regs_m[pend_reg_m] = rw;
      pend_m = 1'b0;
    end else begin
      opc = word[31:28];
      a = word[8:6];
      b = word[5:3];
      c = word[2:0];
      pend_m = 1'b0;
      pc_m = pc_m + 32'd1;
      case (opc)
        OP_CMOV: if (regs_m[c] != 0) regs_m[a] = regs_m[b];
        OP_READ: begin
          r.kind = K_READ; r.aid = regs_m[b]; r.off = regs_m[c];
          pend_reg_m = a; pend_m = 1'b1;
        end
        OP_WRITE: begin
          r.kind = K_WRITE; r.aid = regs_m[a]; r.off = regs_m[b]; r.data = regs_m[c];
        end
        OP_ADD: regs_m[a] = regs_m[b] + regs_m[c];
        OP_MUL: regs_m[a] = regs_m[b] * regs_m[c];
        OP_DIV: begin
          if (regs_m[c] == 0) r.kind = K_FAULT;
          else regs_m[a] = regs_m[b] / regs_m[c];
        end
        OP_NAND: regs_m[a] = ~(regs_m[b] & regs_m[c]);
        OP_HALT: r.kind = K_HALT;
        OP_ALLOC: begin
          r.kind = K_ALLOC; r.off = regs_m[c]; pend_reg_m = b; pend_m = 1'b1;
        end
        OP_FREE: begin
          r.kind = K_FREE; r.aid = regs_m[c];
        end
        OP_OUT: begin
          if (regs_m[c] > OutMax) r.kind = K_FAULT;
          else begin
            r.kind = K_OUT; r.data = regs_m[c];
          end
        end
        OP_IN: begin
          r.kind = K_IN; pend_reg_m = c; pend_m = 1'b1;
        end
        OP_LOAD: begin
          r.kind = K_LOAD; r.aid = regs_m[b]; pc_m = regs_m[c];
        end
        OP_ORTHO: regs_m[word[27:25]] = {7'd0, word[24:0]};
        default: r.kind = K_FAULT;
      endcase
    end
    r.pc = pc_m;
    return r;
  endfunction

  task automatic send_word(logic resp, logic [31:0] word, logic [31:0] rw,
                           logic typed, result_t typed_res);
    result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= resp;
    in_tdata <= {rw, word};
    do @(posedge clk); while (!in_tready);
    r = execute_word(resp, word, rw);
    if (typed && r !== typed_res) begin
      $display("table row disagrees with prediction: %h vs %h", typed_res, r);
      mismatches++;
    end
    expected_q.push_back(typed ? typed_res : r);
    words_sent++;
  endtask

  function automatic logic [31:0] op_word(opc_t o, int a, int b, int c);
    return {o, 19'd0, a[2:0], b[2:0], c[2:0]};
  endfunction

  function automatic logic [31:0] ortho_word(int a, logic [24:0] v);
    return {OP_ORTHO, a[2:0], v};
  endfunction

  function automatic stim_t row(logic resp, logic [31:0] w, logic [31:0] rw,
                                logic typed, kind_t k, logic [31:0] pc);
    stim_t s;
    s.resp = resp;
    s.word = resp ? rw : w;
    s.typed = typed;
    s.res = '{kind: k, pc: pc, default: '0};
    return s;
  endfunction

  always @(posedge clk) begin
    result_t got, exp_r;
    if (out_tvalid && out_tready) begin
      got = {kind_t'(out_tuser), out_tdata[31:0], out_tdata[63:32],
             out_tdata[95:64], out_tdata[127:96]};
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch kind %0d/%0d aid %h/%h off %h/%h data %h/%h pc %h/%h",
                     exp_r.kind, got.kind, exp_r.aid, got.aid, exp_r.off, got.off,
                     exp_r.data, got.data, exp_r.pc, got.pc);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_t s;
    int unsigned sel;
    logic [31:0] w;
    for (int i = 0; i < 8; i++) regs_m[i] = '0;
    pc_m = '0;
    pend_reg_m = '0;
    pend_m = 1'b0;

    // fresh state: all registers zero
    table_d.push_back(row(1, 0, 32'h1234, 1, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_DIV, 1, 2, 3), 0, 1, K_FAULT, 1));
    table_d.push_back(row(0, op_word(OP_HALT, 0, 0, 0), 0, 1, K_HALT, 2));
    table_d.push_back(row(0, 32'hE000_0000, 0, 1, K_FAULT, 3));
    table_d.push_back(row(0, 32'hFFFF_FFFF, 0, 1, K_FAULT, 4));
    table_d.push_back(row(0, ortho_word(7, 25'h1ffffff), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, ortho_word(0, 25'd0), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_IN, 0, 0, 2), 0, 0, K_DONE, 0));
    table_d.push_back(row(1, 0, 32'hffffffff, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_OUT, 0, 0, 2), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_READ, 4, 2, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_ADD, 3, 2, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(1, 0, 32'hdead, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_ALLOC, 0, 5, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(1, 0, 32'h80000000, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_MUL, 6, 2, 5), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_DIV, 1, 2, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_NAND, 1, 1, 1), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_CMOV, 4, 7, 1), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_CMOV, 4, 7, 0), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_WRITE, 2, 5, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_FREE, 0, 0, 5), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_OUT, 0, 0, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_LOAD, 0, 5, 7), 0, 0, K_DONE, 0));
    table_d.push_back(row(0, op_word(OP_IN, 0, 0, 3), 0, 0, K_DONE, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_d[i]) begin
      s = table_d[i];
      send_word(s.resp, s.resp ? 32'd0 : s.word, s.resp ? s.word : 32'd0,
                s.typed, s.res);
    end

    for (int n = 0; n < RandWords; n++) begin
      if (n == 300) begin
        hold_rx <= 1'b1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      if (n == 600) begin
        in_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (n == RandWords - 150) quiet <= 1'b1;
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        send_word(1'b1, $urandom, rand_val(), 1'b0, '0);
      end else if (sel < 7) begin
        w = ortho_word($urandom_range(0, 7), 25'($urandom));
        if ($urandom_range(0, 3) == 0) w[24:0] = 25'($urandom_range(0, 300));
        send_word(1'b0, w, $urandom, 1'b0, '0);
      end else begin
        w = $urandom;
        w[31:28] = 4'($urandom_range(0, 15));
        send_word(1'b0, w, $urandom, 1'b0, '0);
        if (w[31:28] inside {OP_READ, OP_ALLOC, OP_IN} && $urandom_range(0, 3) != 0)
          send_word(1'b1, $urandom, rand_val(), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d words, checked %0d results, all opcodes, responses and faults",
             words_sent, words_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/amx_pkg.sv
src/amx_ctrl.sv
src/amx_dp.sv
src/array_machine_execute_unit_core.sv
bench/array_machine_execute_unit_core_test.sv
